[hw/rtl/lacc_pkg.sv]
`default_nettype none

package lacc_pkg;

  localparam int MAX_LINES = 1024;
  localparam int MAX_WAYS  = 16;
  localparam int LINE_AW   = $clog2(MAX_LINES);
  localparam int IDX_W     = LINE_AW + 2;
  localparam int LINES_W   = LINE_AW + 1;
  localparam int AGE_W     = 5;
  localparam int BYTE_AW   = 20;
  localparam int SUM_W     = BYTE_AW + 1;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;

  localparam logic [3:0]         LSZ_MAX       = 4'd8;
  localparam logic [3:0]         SETS_LOG2_MAX = 4'(LINE_AW);
  localparam logic [3:0]         RESET_LSZ     = 4'd6;
  localparam logic [3:0]         RESET_SETS    = 4'd6;
  localparam logic [AGE_W-1:0]   RESET_WAYS    = AGE_W'(4);
  localparam logic [LINES_W-1:0] RESET_LINES   = LINES_W'(MAX_LINES);

  typedef enum logic [1:0] {
    OP_ACCESS     = 2'd0,
    OP_FORCE      = 2'd1,
    OP_INVALIDATE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_MISS      = 3'd0,
    ST_HIT       = 3'd1,
    ST_BEYOND    = 3'd2,
    ST_UNTRACKED = 3'd3,
    ST_DONE      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    REG_LINE_SIZE = 3'd0,
    REG_SET_COUNT = 3'd1,
    REG_WAYS      = 3'd2,
    REG_MUST_MODE = 3'd3,
    REG_LINES     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [3:0]         lsz;
    logic [3:0]         sets_log2;
    logic [AGE_W-1:0]   ways;
    logic               must;
    logic [LINES_W-1:0] lines;
  } cfg_t;

  typedef struct packed {
    logic               wr_en;
    logic [LINE_AW-1:0] wr_addr;
    logic [AGE_W-1:0]   wr_data;
    logic               rd_en;
    logic [LINE_AW-1:0] rd_addr;
  } mem_req_t;

endpackage

`default_nettype wire

[hw/rtl/lru_age_cache_classifier_unit.sv]
// LRU age cache classifier. One age per tracked memory line is held in a
// single 1024-entry memory with one write and one registered read port. For
// an access item the memory port reads and rewrites one line of the accessed
// set per cycle. A force item zeroes the tracked lines of its range, and an
// invalidate item rewrites every memory entry, one per cycle. After reset a
// clearing pass marks every line uncached, and in_ready stays low until it
// ends. One item is worked on at a time; a finished result waits in the
// output register while the next item is accepted.
`default_nettype none

module lru_age_cache_classifier_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [lacc_pkg::PADDR_W-1:0]    cfg_paddr,
  input  logic [lacc_pkg::PDATA_W-1:0]    cfg_pwdata,
  output logic [lacc_pkg::PDATA_W-1:0]    cfg_prdata,
  output logic                            cfg_pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_operation,
  input  logic [lacc_pkg::BYTE_AW-1:0]    in_var_base,
  input  logic [lacc_pkg::BYTE_AW-1:0]    in_var_end,
  input  logic [lacc_pkg::BYTE_AW-1:0]    in_offset,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_status,
  output logic [lacc_pkg::AGE_W-1:0]      out_age_before
);

  lacc_pkg::cfg_t                 cfg;
  lacc_pkg::mem_req_t             mem_req;
  logic [lacc_pkg::AGE_W-1:0]     mem_rd_data;

  lacc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  lacc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_var_base    (in_var_base),
    .in_var_end     (in_var_end),
    .in_offset      (in_offset),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_age_before (out_age_before),
    .mem_req        (mem_req),
    .mem_rd_data    (mem_rd_data)
  );

  lacc_ram #(
    .WIDTH (lacc_pkg::AGE_W),
    .DEPTH (lacc_pkg::MAX_LINES)
  ) u_ages (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

`default_nettype wire

[hw/rtl/lacc_ram.sv]
`default_nettype none

module lacc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[hw/rtl/lacc_cfg.sv]
`default_nettype none

module lacc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lacc_pkg::PADDR_W-1:0]    paddr,
  input  logic [lacc_pkg::PDATA_W-1:0]    pwdata,
  output logic [lacc_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  output lacc_pkg::cfg_t                  cfg
);

  logic [3:0]                      lsz_r;
  logic [3:0]                      sets_r;
  logic [lacc_pkg::AGE_W-1:0]      ways_r;
  logic                            must_r;
  logic [lacc_pkg::LINES_W-1:0]    lines_r;
  logic                            wr_en;
  lacc_pkg::reg_idx_t              idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = lacc_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lsz_r   <= lacc_pkg::RESET_LSZ;
      sets_r  <= lacc_pkg::RESET_SETS;
      ways_r  <= lacc_pkg::RESET_WAYS;
      must_r  <= 1'b0;
      lines_r <= lacc_pkg::RESET_LINES;
    end else if (wr_en) begin
      case (idx)
        lacc_pkg::REG_LINE_SIZE: lsz_r   <= pwdata[3:0];
        lacc_pkg::REG_SET_COUNT: sets_r  <= pwdata[3:0];
        lacc_pkg::REG_WAYS:      ways_r  <= pwdata[lacc_pkg::AGE_W-1:0];
        lacc_pkg::REG_MUST_MODE: must_r  <= pwdata[0];
        lacc_pkg::REG_LINES:     lines_r <= pwdata[lacc_pkg::LINES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      lacc_pkg::REG_LINE_SIZE: prdata = lacc_pkg::PDATA_W'(lsz_r);
      lacc_pkg::REG_SET_COUNT: prdata = lacc_pkg::PDATA_W'(sets_r);
      lacc_pkg::REG_WAYS:      prdata = lacc_pkg::PDATA_W'(ways_r);
      lacc_pkg::REG_MUST_MODE: prdata = lacc_pkg::PDATA_W'(must_r);
      lacc_pkg::REG_LINES:     prdata = lacc_pkg::PDATA_W'(lines_r);
      default:                 prdata = '0;
    endcase
  end

  // Out-of-range settings are clamped to the nearest supported value.
  always_comb begin
    cfg.lsz       = (lsz_r > lacc_pkg::LSZ_MAX) ? lacc_pkg::LSZ_MAX : lsz_r;
    cfg.sets_log2 = (sets_r > lacc_pkg::SETS_LOG2_MAX) ? lacc_pkg::SETS_LOG2_MAX : sets_r;
    if (ways_r == '0) begin
      cfg.ways = lacc_pkg::AGE_W'(1);
    end else if (ways_r > lacc_pkg::AGE_W'(lacc_pkg::MAX_WAYS)) begin
      cfg.ways = lacc_pkg::AGE_W'(lacc_pkg::MAX_WAYS);
    end else begin
      cfg.ways = ways_r;
    end
    cfg.must  = must_r;
    cfg.lines = (lines_r > lacc_pkg::LINES_W'(lacc_pkg::MAX_LINES)) ?
                lacc_pkg::LINES_W'(lacc_pkg::MAX_LINES) : lines_r;
  end

endmodule

`default_nettype wire

[hw/rtl/lacc_ctrl.sv]
`default_nettype none

module lacc_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lacc_pkg::cfg_t                  cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_operation,
  input  logic [lacc_pkg::BYTE_AW-1:0]    in_var_base,
  input  logic [lacc_pkg::BYTE_AW-1:0]    in_var_end,
  input  logic [lacc_pkg::BYTE_AW-1:0]    in_offset,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_status,
  output logic [lacc_pkg::AGE_W-1:0]      out_age_before,
  output lacc_pkg::mem_req_t              mem_req,
  input  logic [lacc_pkg::AGE_W-1:0]      mem_rd_data
);

  typedef enum logic [10:0] {
    SX_CLEAR  = 11'b00000000001,
    SX_IDLE   = 11'b00000000010,
    SX_ADDR   = 11'b00000000100,
    SX_CHECK  = 11'b00000001000,
    SX_TRACK  = 11'b00000010000,
    SX_RDLINE = 11'b00000100000,
    SX_SWEEP  = 11'b00001000000,
    SX_FSETUP = 11'b00010000000,
    SX_FRANGE = 11'b00100000000,
    SX_FILL   = 11'b01000000000,
    SX_DONE   = 11'b10000000000
  } state_t;

  state_t                              state_r, state_nxt;
  logic [lacc_pkg::IDX_W-1:0]          idx_r, idx_nxt;
  logic                                out_valid_r, out_valid_nxt;

  logic [lacc_pkg::BYTE_AW-1:0]        base_r, base_nxt;
  logic [lacc_pkg::BYTE_AW-1:0]        vend_r, vend_nxt;
  logic [lacc_pkg::BYTE_AW-1:0]        off_r, off_nxt;
  logic [lacc_pkg::SUM_W-1:0]          addr_r, addr_nxt;
  logic [lacc_pkg::SUM_W-1:0]          line_full_r, line_full_nxt;
  logic                                empty_r, empty_nxt;
  logic [lacc_pkg::LINE_AW-1:0]        line_r, line_nxt;
  logic [lacc_pkg::LINE_AW-1:0]        pend_r, pend_nxt;
  logic [lacc_pkg::LINES_W-1:0]        limit_r, limit_nxt;
  logic [lacc_pkg::AGE_W-1:0]          fill_r, fill_nxt;
  logic [lacc_pkg::AGE_W-1:0]          age_r, age_nxt;
  lacc_pkg::status_t                   res_status_r, res_status_nxt;
  logic [lacc_pkg::AGE_W-1:0]          res_age_r, res_age_nxt;
  lacc_pkg::status_t                   out_status_r, out_status_nxt;
  logic [lacc_pkg::AGE_W-1:0]          out_age_r, out_age_nxt;

  logic [lacc_pkg::IDX_W-1:0]          step;
  logic [lacc_pkg::LINE_AW-1:0]        set_mask;
  logic [lacc_pkg::LINES_W-1:0]        limit_v;
  logic [lacc_pkg::AGE_W-1:0]          new_age;
  logic                                do_age;

  assign in_ready       = (state_r == SX_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_age_before = out_age_r;

  assign step     = lacc_pkg::IDX_W'(1) << cfg.sets_log2;
  assign set_mask = lacc_pkg::LINE_AW'(step - lacc_pkg::IDX_W'(1));

  assign limit_v = (line_full_r >= lacc_pkg::SUM_W'(cfg.lines)) ? cfg.lines :
                   lacc_pkg::LINES_W'(line_full_r) + lacc_pkg::LINES_W'(1);

  // Lines of the set no older than the accessed line move one step toward
  // eviction; in must mode lines of exactly that age stay where they are.
  assign do_age  = (mem_rd_data <= age_r) && !((mem_rd_data == age_r) && cfg.must) &&
                   (mem_rd_data < cfg.ways);
  assign new_age = (pend_r == line_r) ? '0 :
                   do_age ? mem_rd_data + lacc_pkg::AGE_W'(1) : mem_rd_data;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    base_nxt       = base_r;
    vend_nxt       = vend_r;
    off_nxt        = off_r;
    addr_nxt       = addr_r;
    line_full_nxt  = line_full_r;
    empty_nxt      = empty_r;
    line_nxt       = line_r;
    pend_nxt       = pend_r;
    limit_nxt      = limit_r;
    fill_nxt       = fill_r;
    age_nxt        = age_r;
    res_status_nxt = res_status_r;
    res_age_nxt    = res_age_r;
    out_status_nxt = out_status_r;
    out_age_nxt    = out_age_r;
    mem_req        = '0;

    case (state_r)
      SX_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = idx_r[lacc_pkg::LINE_AW-1:0];
        mem_req.wr_data = lacc_pkg::RESET_WAYS;
        idx_nxt         = idx_r + lacc_pkg::IDX_W'(1);
        if (idx_r == lacc_pkg::IDX_W'(lacc_pkg::MAX_LINES - 1)) begin
          idx_nxt   = '0;
          state_nxt = SX_IDLE;
        end
      end
      SX_IDLE: begin
        if (in_valid) begin
          base_nxt       = in_var_base;
          vend_nxt       = in_var_end;
          off_nxt        = in_offset;
          res_status_nxt = lacc_pkg::ST_DONE;
          res_age_nxt    = cfg.ways;
          case (lacc_pkg::op_t'(in_operation))
            lacc_pkg::OP_ACCESS: state_nxt = SX_ADDR;
            lacc_pkg::OP_FORCE:  state_nxt = SX_FSETUP;
            lacc_pkg::OP_INVALIDATE: begin
              idx_nxt   = '0;
              limit_nxt = lacc_pkg::LINES_W'(lacc_pkg::MAX_LINES);
              fill_nxt  = cfg.ways;
              state_nxt = SX_FILL;
            end
            default: state_nxt = SX_DONE;
          endcase
        end
      end
      SX_ADDR: begin
        addr_nxt  = lacc_pkg::SUM_W'(base_r) + lacc_pkg::SUM_W'(off_r);
        state_nxt = SX_CHECK;
      end
      SX_CHECK: begin
        if (addr_r > lacc_pkg::SUM_W'(vend_r)) begin
          res_status_nxt = lacc_pkg::ST_BEYOND;
          state_nxt      = SX_DONE;
        end else begin
          line_full_nxt = addr_r >> cfg.lsz;
          state_nxt     = SX_TRACK;
        end
      end
      SX_TRACK: begin
        if (line_full_r >= lacc_pkg::SUM_W'(cfg.lines)) begin
          res_status_nxt = lacc_pkg::ST_UNTRACKED;
          state_nxt      = SX_DONE;
        end else begin
          line_nxt        = line_full_r[lacc_pkg::LINE_AW-1:0];
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = line_full_r[lacc_pkg::LINE_AW-1:0];
          idx_nxt         = lacc_pkg::IDX_W'(line_full_r[lacc_pkg::LINE_AW-1:0] & set_mask);
          state_nxt       = SX_RDLINE;
        end
      end
      SX_RDLINE: begin
        age_nxt         = mem_rd_data;
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = idx_r[lacc_pkg::LINE_AW-1:0];
        pend_nxt        = idx_r[lacc_pkg::LINE_AW-1:0];
        idx_nxt         = idx_r + step;
        state_nxt       = SX_SWEEP;
      end
      SX_SWEEP: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = pend_r;
        mem_req.wr_data = new_age;
        if (idx_r < lacc_pkg::IDX_W'(cfg.lines)) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = idx_r[lacc_pkg::LINE_AW-1:0];
          pend_nxt        = idx_r[lacc_pkg::LINE_AW-1:0];
          idx_nxt         = idx_r + step;
        end else begin
          res_status_nxt = (age_r < cfg.ways) ? lacc_pkg::ST_HIT : lacc_pkg::ST_MISS;
          res_age_nxt    = age_r;
          state_nxt      = SX_DONE;
        end
      end
      SX_FSETUP: begin
        addr_nxt      = lacc_pkg::SUM_W'(base_r >> cfg.lsz);
        line_full_nxt = lacc_pkg::SUM_W'(vend_r >> cfg.lsz);
        empty_nxt     = base_r > vend_r;
        state_nxt     = SX_FRANGE;
      end
      SX_FRANGE: begin
        if (empty_r || (addr_r >= lacc_pkg::SUM_W'(limit_v))) begin
          state_nxt = SX_DONE;
        end else begin
          idx_nxt   = lacc_pkg::IDX_W'(addr_r);
          limit_nxt = limit_v;
          fill_nxt  = '0;
          state_nxt = SX_FILL;
        end
      end
      SX_FILL: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = idx_r[lacc_pkg::LINE_AW-1:0];
        mem_req.wr_data = fill_r;
        idx_nxt         = idx_r + lacc_pkg::IDX_W'(1);
        if ((idx_r + lacc_pkg::IDX_W'(1)) >= lacc_pkg::IDX_W'(limit_r)) begin
          state_nxt = SX_DONE;
        end
      end
      SX_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_age_nxt    = res_age_r;
          state_nxt      = SX_IDLE;
        end
      end
      default: state_nxt = SX_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SX_CLEAR;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r       <= base_nxt;
    vend_r       <= vend_nxt;
    off_r        <= off_nxt;
    addr_r       <= addr_nxt;
    line_full_r  <= line_full_nxt;
    empty_r      <= empty_nxt;
    line_r       <= line_nxt;
    pend_r       <= pend_nxt;
    limit_r      <= limit_nxt;
    fill_r       <= fill_nxt;
    age_r        <= age_nxt;
    res_status_r <= res_status_nxt;
    res_age_r    <= res_age_nxt;
    out_status_r <= out_status_nxt;
    out_age_r    <= out_age_nxt;
  end

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en && mem_req.rd_en |-> mem_req.wr_addr != mem_req.rd_addr)
    else $error("memory read and write hit the same entry in one cycle");

  a_sweep_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == SX_SWEEP |-> lacc_pkg::LINES_W'(pend_r) < cfg.lines)
    else $error("set sweep touched an untracked line");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == SX_FILL |-> idx_r < lacc_pkg::IDX_W'(limit_r))
    else $error("fill pass ran past its limit");

  a_hit_age: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == SX_DONE && res_status_r == lacc_pkg::ST_HIT |-> res_age_r < cfg.ways)
    else $error("hit reported for a line that is not cached");

endmodule

`default_nettype wire

[dv/lru_age_cache_classifier_unit_tb.sv]
`timescale 1ns / 1ps

module lru_age_cache_classifier_unit_tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 6_000_000;

  typedef struct {
    logic [1:0]                   op;
    logic [lacc_pkg::BYTE_AW-1:0] base;
    logic [lacc_pkg::BYTE_AW-1:0] vend;
    logic [lacc_pkg::BYTE_AW-1:0] off;
  } request_t;

  typedef struct {
    lacc_pkg::status_t          status;
    logic [lacc_pkg::AGE_W-1:0] age;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [lacc_pkg::PADDR_W-1:0] cfg_paddr = '0;
  logic [lacc_pkg::PDATA_W-1:0] cfg_pwdata = '0;
  logic [lacc_pkg::PDATA_W-1:0] cfg_prdata;
  logic cfg_pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = '0;
  logic [lacc_pkg::BYTE_AW-1:0] in_var_base = '0;
  logic [lacc_pkg::BYTE_AW-1:0] in_var_end = '0;
  logic [lacc_pkg::BYTE_AW-1:0] in_offset = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_status;
  logic [lacc_pkg::AGE_W-1:0] out_age_before;

  lru_age_cache_classifier_unit uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_var_base   (in_var_base),
    .in_var_end    (in_var_end),
    .in_offset     (in_offset),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_age_before(out_age_before)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [3:0]                   m_lsz = lacc_pkg::RESET_LSZ;
  logic [3:0]                   m_sets = lacc_pkg::RESET_SETS;
  logic [lacc_pkg::AGE_W-1:0]   m_ways = lacc_pkg::RESET_WAYS;
  logic                         m_must = 1'b0;
  logic [lacc_pkg::LINES_W-1:0] m_lines = lacc_pkg::RESET_LINES;
  logic [lacc_pkg::AGE_W-1:0]   line_age [lacc_pkg::MAX_LINES];

  request_t pending_requests[$];
  verdict_t pending_verdicts[$];
  int queued_total = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int idle_pct = 0;
  int send_gap = 0;
  int hold_left = 0;

  function automatic int eff_ways();
    if (m_ways == 0) return 1;
    if (m_ways > lacc_pkg::MAX_WAYS) return lacc_pkg::MAX_WAYS;
    return int'(m_ways);
  endfunction

  function automatic int eff_lines();
    return (m_lines > lacc_pkg::MAX_LINES) ? lacc_pkg::MAX_LINES : int'(m_lines);
  endfunction

  function automatic int eff_lsz();
    return (m_lsz > lacc_pkg::LSZ_MAX) ? int'(lacc_pkg::LSZ_MAX) : int'(m_lsz);
  endfunction

  function automatic int eff_sets_log2();
    return (m_sets > lacc_pkg::SETS_LOG2_MAX) ? int'(lacc_pkg::SETS_LOG2_MAX) : int'(m_sets);
  endfunction

  // Updates the line ages for one item and returns the result it must produce.
  function automatic void classify_item(input request_t r, output verdict_t v);
    int w;
    int nl;
    int lsz;
    int step;
    int line;
    int age;
    int first;
    int last;
    logic [lacc_pkg::BYTE_AW:0] addr;
    w = eff_ways();
    nl = eff_lines();
    lsz = eff_lsz();
    step = 1 << eff_sets_log2();
    v.status = lacc_pkg::ST_DONE;
    v.age = lacc_pkg::AGE_W'(w);
    if (r.op == lacc_pkg::OP_ACCESS) begin
      addr = {1'b0, r.base} + {1'b0, r.off};
      if (addr > {1'b0, r.vend}) begin
        v.status = lacc_pkg::ST_BEYOND;
      end else begin
        line = int'(addr >> lsz);
        if (line >= nl) begin
          v.status = lacc_pkg::ST_UNTRACKED;
        end else begin
          age = int'(line_age[line]);
          for (int i = line & (step - 1); i < nl; i += step) begin
            if (i == line) begin
              line_age[i] = '0;
            end else if (int'(line_age[i]) < age ||
                         (int'(line_age[i]) == age && !m_must)) begin
              if (int'(line_age[i]) < w) line_age[i] = line_age[i] + 1'b1;
            end
          end
          v.age = lacc_pkg::AGE_W'(age);
          v.status = (age < w) ? lacc_pkg::ST_HIT : lacc_pkg::ST_MISS;
        end
      end
    end else if (r.op == lacc_pkg::OP_FORCE) begin
      if (r.base <= r.vend) begin
        first = int'(r.base) >> lsz;
        last = int'(r.vend) >> lsz;
        if (nl > 0 && last >= nl) last = nl - 1;
        for (int i = first; i <= last && i < nl; i++) line_age[i] = '0;
      end
    end else if (r.op == lacc_pkg::OP_INVALIDATE) begin
      for (int i = 0; i < lacc_pkg::MAX_LINES; i++) line_age[i] = lacc_pkg::AGE_W'(w);
    end
  endfunction

  always @(posedge clk) begin
    bit fire;
    request_t req;
    verdict_t v;
    fire = in_valid && in_ready;
    if (fire) begin
      req.op = in_operation;
      req.base = in_var_base;
      req.vend = in_var_end;
      req.off = in_offset;
      classify_item(req, v);
      pending_verdicts.insert(pending_verdicts.size(), v);
    end
    if (!in_valid || fire) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (fire && $urandom_range(0, 99) < idle_pct) begin
        send_gap <= $urandom_range(0, 5);
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        req = pending_requests.pop_front();
        in_operation <= req.op;
        in_var_base <= req.base;
        in_var_end <= req.vend;
        in_offset <= req.off;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (out_valid && out_ready) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        $error("unexpected item: status %0d, age_before %0d", out_status, out_age_before);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          mismatches++;
        end
        if (out_age_before !== want.age) begin
          $error("age_before: expected %0d, actual %0d", want.age, out_age_before);
          mismatches++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 299) < idle_pct) begin
      hold_left <= $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic add_req(input logic [1:0] op, input logic [lacc_pkg::BYTE_AW-1:0] base,
                         input logic [lacc_pkg::BYTE_AW-1:0] vend,
                         input logic [lacc_pkg::BYTE_AW-1:0] off);
    request_t r;
    r.op = op;
    r.base = base;
    r.vend = vend;
    r.off = off;
    pending_requests.insert(pending_requests.size(), r);
    queued_total++;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (results_seen != queued_total);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input lacc_pkg::reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      lacc_pkg::REG_LINE_SIZE: m_lsz = value[3:0];
      lacc_pkg::REG_SET_COUNT: m_sets = value[3:0];
      lacc_pkg::REG_WAYS:      m_ways = value[lacc_pkg::AGE_W-1:0];
      lacc_pkg::REG_MUST_MODE: m_must = value[0];
      lacc_pkg::REG_LINES:     m_lines = value[lacc_pkg::LINES_W-1:0];
      default: ;
    endcase
  endtask

  function automatic void pick_variable(input int span, input int lsz,
                                        output logic [lacc_pkg::BYTE_AW-1:0] b,
                                        output logic [lacc_pkg::BYTE_AW-1:0] e,
                                        output int sz);
    int last;
    sz = $urandom_range(1, 3 << lsz);
    b = lacc_pkg::BYTE_AW'($urandom_range(0, span - 1));
    last = int'(b) + sz - 1;
    e = (last > 20'hFFFFF) ? 20'hFFFFF : lacc_pkg::BYTE_AW'(last);
  endfunction

  // Most items touch a small set of variables inside the tracked range so
  // that hits, evictions and aging within a set actually happen.
  task automatic queue_workload(input int count);
    int lsz;
    int span;
    int kind;
    int k;
    int ps[8];
    logic [lacc_pkg::BYTE_AW-1:0] pb[8];
    logic [lacc_pkg::BYTE_AW-1:0] pe[8];
    lsz = eff_lsz();
    span = ((eff_lines() == 0) ? 1 : eff_lines()) << lsz;
    for (int p = 0; p < 8; p++) pick_variable(span, lsz, pb[p], pe[p], ps[p]);
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 7);
      if ($urandom_range(0, 19) == 0) pick_variable(span, lsz, pb[k], pe[k], ps[k]);
      kind = $urandom_range(0, 99);
      if (kind < 62) begin
        add_req(lacc_pkg::OP_ACCESS, pb[k], pe[k],
                lacc_pkg::BYTE_AW'($urandom_range(0, ps[k] - 1)));
      end else if (kind < 70) begin
        add_req(lacc_pkg::OP_ACCESS, pb[k], pe[k],
                lacc_pkg::BYTE_AW'(ps[k] + $urandom_range(0, 15)));
      end else if (kind < 78) begin
        add_req(lacc_pkg::OP_FORCE, pb[k], pe[k], lacc_pkg::BYTE_AW'($urandom));
      end else if (kind < 80) begin
        add_req(OP_UNUSED, lacc_pkg::BYTE_AW'($urandom), lacc_pkg::BYTE_AW'($urandom),
                lacc_pkg::BYTE_AW'($urandom));
      end else if (kind == 80) begin
        add_req(lacc_pkg::OP_INVALIDATE, lacc_pkg::BYTE_AW'($urandom),
                lacc_pkg::BYTE_AW'($urandom), lacc_pkg::BYTE_AW'($urandom));
      end else begin
        case ($urandom_range(0, 2))
          0: add_req(lacc_pkg::OP_ACCESS, lacc_pkg::BYTE_AW'($urandom),
                     lacc_pkg::BYTE_AW'($urandom), lacc_pkg::BYTE_AW'($urandom));
          1: add_req(lacc_pkg::OP_FORCE, lacc_pkg::BYTE_AW'($urandom),
                     lacc_pkg::BYTE_AW'($urandom), lacc_pkg::BYTE_AW'($urandom));
          default: add_req(OP_UNUSED, lacc_pkg::BYTE_AW'($urandom),
                           lacc_pkg::BYTE_AW'($urandom), lacc_pkg::BYTE_AW'($urandom));
        endcase
      end
    end
  endtask

  initial begin
    int ph_lsz[9]   = '{0, 8, 3, 15, 4, 5, 6, 2, 6};
    int ph_sets[9]  = '{10, 4, 2, 15, 0, 3, 6, 5, 0};
    int ph_ways[9]  = '{1, 16, 8, 0, 31, 2, 4, 5, 4};
    int ph_must[9]  = '{0, 1, 0, 1, 0, 1, 0, 0, 1};
    int ph_lines[9] = '{1024, 1024, 512, 2047, 40, 300, 0, 1024, 1024};
    int ph_items[9] = '{200, 200, 150, 200, 200, 200, 30, 200, 30};
    int ph_idle[9]  = '{25, 0, 10, 30, 20, 15, 10, 0, 0};
    for (int i = 0; i < lacc_pkg::MAX_LINES; i++) line_age[i] = lacc_pkg::RESET_WAYS;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct = 15;
    add_req(lacc_pkg::OP_ACCESS, 20'd0, 20'd0, 20'd0);
    add_req(lacc_pkg::OP_ACCESS, 20'd0, 20'd0, 20'd0);
    add_req(lacc_pkg::OP_ACCESS, 20'd0, 20'd63, 20'd63);
    add_req(lacc_pkg::OP_ACCESS, 20'd0, 20'd63, 20'd64);
    add_req(lacc_pkg::OP_ACCESS, 20'd100, 20'd50, 20'd0);
    add_req(lacc_pkg::OP_ACCESS, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    add_req(lacc_pkg::OP_ACCESS, 20'hFFFFF, 20'hFFFFF, 20'd0);
    add_req(lacc_pkg::OP_ACCESS, 20'd0, 20'hFFFFF, 20'd65535);
    add_req(lacc_pkg::OP_ACCESS, 20'd0, 20'hFFFFF, 20'd65536);
    add_req(lacc_pkg::OP_FORCE, 20'd0, 20'd4095, 20'd0);
    add_req(lacc_pkg::OP_FORCE, 20'd10, 20'd5, 20'd0);
    add_req(lacc_pkg::OP_FORCE, 20'd65000, 20'hFFFFF, 20'd0);
    add_req(lacc_pkg::OP_ACCESS, 20'd4096, 20'd4096, 20'd0);
    add_req(lacc_pkg::OP_ACCESS, 20'd0, 20'd0, 20'd0);
    add_req(lacc_pkg::OP_ACCESS, 20'd65472, 20'hFFFFF, 20'd0);
    add_req(OP_UNUSED, 20'hFFFFF, 20'd0, 20'hFFFFF);
    add_req(lacc_pkg::OP_INVALIDATE, 20'd0, 20'd0, 20'd0);
    add_req(lacc_pkg::OP_ACCESS, 20'd0, 20'd0, 20'd0);
    add_req(lacc_pkg::OP_FORCE, 20'd0, 20'd0, 20'd0);
    queue_workload(200);
    wait_drained();

    for (int p = 0; p < 9; p++) begin
      cfg_write(lacc_pkg::REG_LINE_SIZE, ph_lsz[p]);
      cfg_write(lacc_pkg::REG_SET_COUNT, ph_sets[p]);
      cfg_write(lacc_pkg::REG_WAYS, ph_ways[p]);
      cfg_write(lacc_pkg::REG_MUST_MODE, ph_must[p]);
      cfg_write(lacc_pkg::REG_LINES, ph_lines[p]);
      idle_pct = ph_idle[p];
      if (p == 1) begin
        queue_workload(ph_items[p] / 2);
        wait_drained();
        queue_workload(ph_items[p] / 2);
      end else begin
        queue_workload(ph_items[p]);
      end
      wait_drained();
    end

    repeat (16) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0 && results_seen == queued_total)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

[files.f]
hw/rtl/lacc_pkg.sv
hw/rtl/lacc_ram.sv
hw/rtl/lacc_cfg.sv
hw/rtl/lacc_ctrl.sv
hw/rtl/lru_age_cache_classifier_unit.sv
dv/lru_age_cache_classifier_unit_tb.sv
